// ===== design/assert_macros.svh =====
// ------------------------------------------------------------------------
// Assertion macros
// Clocked property checks shared by the inverse 5/3 line blocks.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, disabled during reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/idwt53_pkg.sv =====
// ------------------------------------------------------------------------
// idwt53_pkg
// Types and constants shared by the inverse 5/3 horizontal line stages.
// ------------------------------------------------------------------------
package idwt53_pkg;

    localparam int LOW_W     = 32;
    localparam int HIGH_W    = 16;
    localparam int SAMPLE_W  = 32;
    localparam int SHIFT_W   = 4;
    localparam int TDATA_W   = 48;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_SHIFT        = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWPASS_PRESCALED = 1'b1;

    // lifting rounding offsets
    localparam logic [SAMPLE_W-1:0] RND_ONE = 32'd1;
    localparam logic [SAMPLE_W-1:0] RND_TWO = 32'd2;

    // one input request as held in the input register
    typedef struct packed {
        logic [LOW_W-1:0]  lowpass;      // signed
        logic [HIGH_W-1:0] highpass;     // signed
        logic              has_highpass;
        logic              line_end;
    } in_item_t;

    // even-sample stage result, handed to the output stage
    typedef struct packed {
        logic [SAMPLE_W-1:0] even;       // new even sample
        logic [SAMPLE_W-1:0] hi;         // shifted high-pass of this pair
        logic [SAMPLE_W-1:0] prev_hi;    // shifted high-pass of the previous pair
        logic [SAMPLE_W-1:0] prev_even;  // previous even sample
        logic                emit_odd;   // odd sample goes out before the even one
        logic                emit_tail;  // closing odd sample after the even one
        logic                even_last;  // even sample ends the line
    } ev_item_t;

endpackage

// ===== design/idwt53_in_stage.sv =====
// ------------------------------------------------------------------------
// idwt53_in_stage
// Input register: captures one coefficient pair per request.
// ------------------------------------------------------------------------
module idwt53_in_stage (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [idwt53_pkg::TDATA_W-1:0]      s_tdata,   // lowpass[31:0], highpass[47:32]
    input  logic                                s_tuser,   // has_highpass
    input  logic                                s_tlast,   // line_end
    output logic                                in_valid,
    output idwt53_pkg::in_item_t                in_item,
    input  logic                                in_take
);
    import idwt53_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     accept;

    assign s_tready = !valid_reg || in_take;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (in_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg.lowpass      <= s_tdata[LOW_W-1:0];
            item_reg.highpass     <= s_tdata[LOW_W+HIGH_W-1:LOW_W];
            item_reg.has_highpass <= s_tuser;
            item_reg.line_end     <= s_tlast;
        end
    end

    assign in_valid = valid_reg;
    assign in_item  = item_reg;

endmodule

// ===== design/idwt53_even_stage.sv =====
// ------------------------------------------------------------------------
// idwt53_even_stage
// Coefficient scaling, even-sample lifting step and line state.
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module idwt53_even_stage (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [idwt53_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [idwt53_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                                in_valid,
    input  idwt53_pkg::in_item_t                in_item,
    output logic                                in_take,
    input  logic                                out_load_ok,
    output logic                                ev_valid,
    output idwt53_pkg::ev_item_t                ev_item
);
    import idwt53_pkg::*;

    logic [SHIFT_W-1:0]  coef_shift_reg;
    logic                prescaled_reg;
    logic [SAMPLE_W-1:0] prev_hi_reg;
    logic [SAMPLE_W-1:0] prev_even_reg;
    logic                at_start_reg;
    logic                ev_valid_reg;
    ev_item_t            ev_item_reg;

    logic                ev_valid_next;
    ev_item_t            ev_item_next;
    logic                fire;
    logic                has_hp;
    logic                both;
    logic [SAMPLE_W-1:0] hi_ext;
    logic [SAMPLE_W-1:0] lo_ext;
    logic [SAMPLE_W-1:0] hi_val;
    logic [SAMPLE_W-1:0] lo_val;
    logic [SAMPLE_W-1:0] sum;
    logic [SAMPLE_W-1:0] sub;
    logic [SAMPLE_W-1:0] even;

    assign in_take = !ev_valid_reg || out_load_ok;
    assign fire    = in_valid && in_take;
    assign has_hp  = in_item.has_highpass;
    // neighbors on both sides: (H[k-1] + H[k] + 2) >> 2, else one-sided (H + 1) >> 1
    assign both    = !at_start_reg && has_hp;

    always_comb begin
        hi_ext = {{(SAMPLE_W-HIGH_W){in_item.highpass[HIGH_W-1]}}, in_item.highpass};
        lo_ext = {{(SAMPLE_W-HIGH_W){in_item.lowpass[HIGH_W-1]}}, in_item.lowpass[HIGH_W-1:0]};
        hi_val = hi_ext << coef_shift_reg;
        lo_val = prescaled_reg ? in_item.lowpass : (lo_ext << coef_shift_reg);
        // first item without high-pass gives sum 1, so the correction is 0
        sum = (at_start_reg ? '0 : prev_hi_reg) + (has_hp ? hi_val : '0)
            + (both ? RND_TWO : RND_ONE);
        sub = both ? {{2{sum[SAMPLE_W-1]}}, sum[SAMPLE_W-1:2]}
                   : {sum[SAMPLE_W-1], sum[SAMPLE_W-1:1]};
        even = lo_val - sub;

        ev_item_next.even      = even;
        ev_item_next.hi        = hi_val;
        ev_item_next.prev_hi   = prev_hi_reg;
        ev_item_next.prev_even = prev_even_reg;
        ev_item_next.emit_odd  = !at_start_reg;
        ev_item_next.emit_tail = has_hp && in_item.line_end;
        ev_item_next.even_last = !has_hp;
    end

    always_comb begin
        ev_valid_next = ev_valid_reg;
        if (fire) begin
            ev_valid_next = 1'b1;
        end else if (out_load_ok) begin
            ev_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_shift_reg <= '0;
            prescaled_reg  <= 1'b0;
            prev_hi_reg    <= '0;
            prev_even_reg  <= '0;
            at_start_reg   <= 1'b1;
            ev_valid_reg   <= 1'b0;
        end else begin
            ev_valid_reg <= ev_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_COEF_SHIFT: begin
                        coef_shift_reg <= cfg_wdata[SHIFT_W-1:0];
                    end
                    CFG_LOWPASS_PRESCALED: begin
                        prescaled_reg <= cfg_wdata[0];
                    end
                    default: begin
                    end
                endcase
            end
            if (fire) begin
                prev_hi_reg   <= has_hp ? hi_val : '0;
                prev_even_reg <= even;
                // a missing high-pass always closes the line
                at_start_reg  <= !has_hp || in_item.line_end;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            ev_item_reg <= ev_item_next;
        end
    end

    assign ev_valid = ev_valid_reg;
    assign ev_item  = ev_item_reg;

    `ASSERT_NEXT(a_close_on_no_hp, aclk, aresetn, fire && !has_hp, at_start_reg, "line not closed after item without high-pass")
    `ASSERT_IMPLY(a_one_last, aclk, aresetn, ev_valid_reg, !(ev_item_reg.emit_tail && ev_item_reg.even_last), "two samples marked last for one pair")
    `ASSERT_IMPLY(a_hold_full, aclk, aresetn, ev_valid_reg && !out_load_ok, !in_take, "even stage overwritten while full")

endmodule

// ===== design/idwt53_out_stage.sv =====
// ------------------------------------------------------------------------
// idwt53_out_stage
// Odd-sample lifting step and three-entry result buffer, one sample out
// per cycle while m_tready is high.
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module idwt53_out_stage (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                ev_valid,
    input  idwt53_pkg::ev_item_t                ev_item,
    output logic                                out_load_ok,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [idwt53_pkg::SAMPLE_W-1:0]     m_tdata,   // sample
    output logic                                m_tlast    // sample_last
);
    import idwt53_pkg::*;

    logic [SAMPLE_W-1:0] buf_data_reg [3];
    logic                buf_last_reg [3];
    logic [1:0]          cnt_reg;
    logic [1:0]          cnt_next;

    logic                pop;
    logic                load;
    logic [SAMPLE_W-1:0] pair_sum;
    logic [SAMPLE_W-1:0] odd;
    logic [SAMPLE_W-1:0] tail;
    logic [SAMPLE_W-1:0] slot_data [3];
    logic                slot_last [3];
    logic [1:0]          load_cnt;

    assign m_tvalid    = (cnt_reg != 2'd0);
    assign m_tdata     = buf_data_reg[0];
    assign m_tlast     = buf_last_reg[0];
    assign pop         = m_tvalid && m_tready;
    // reload when empty or as the last queued sample leaves
    assign out_load_ok = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);
    assign load        = ev_valid && out_load_ok;

    always_comb begin
        pair_sum = ev_item.prev_even + ev_item.even;
        odd      = ev_item.prev_hi + {pair_sum[SAMPLE_W-1], pair_sum[SAMPLE_W-1:1]};
        tail     = ev_item.hi + ev_item.even;

        slot_data[0] = ev_item.emit_odd ? odd : ev_item.even;
        slot_last[0] = ev_item.emit_odd ? 1'b0 : ev_item.even_last;
        slot_data[1] = ev_item.emit_odd ? ev_item.even : tail;
        slot_last[1] = ev_item.emit_odd ? ev_item.even_last : 1'b1;
        slot_data[2] = tail;
        slot_last[2] = 1'b1;
        load_cnt     = 2'd1 + {1'b0, ev_item.emit_odd} + {1'b0, ev_item.emit_tail};
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (load) begin
            cnt_next = load_cnt;
        end else if (pop) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < 3; i++) begin
                buf_data_reg[i] <= slot_data[i];
                buf_last_reg[i] <= slot_last[i];
            end
        end else if (pop) begin
            buf_data_reg[0] <= buf_data_reg[1];
            buf_last_reg[0] <= buf_last_reg[1];
            buf_data_reg[1] <= buf_data_reg[2];
            buf_last_reg[1] <= buf_last_reg[2];
        end
    end

    `ASSERT_IMPLY(a_last_drains, aclk, aresetn, m_tvalid && m_tlast, cnt_reg == 2'd1, "samples queued behind the line end")
    `ASSERT_NEXT(a_stall_keeps, aclk, aresetn, m_tvalid && !m_tready, cnt_reg == $past(cnt_reg), "queue changed while output stalled")

endmodule

// ===== design/inverse_53_dwt_horizontal_line.sv =====
// ------------------------------------------------------------------------
// inverse_53_dwt_horizontal_line
// Inverse 5/3 lifting over one line, coefficient pairs in, samples out.
// ------------------------------------------------------------------------
// Each request carries one low-pass / high-pass pair of a line and yields
// the rebuilt samples in index order, with symmetric extension at both
// ends; a line of odd length ends with a pair whose tuser bit is clear.
// A pair passes an input register, the even-sample stage and the output
// buffer, in that order. The output port moves one sample per cycle while
// m_tready is high, which sets the rate: a pair inside a line yields two
// samples, the first pair of a line one (two for a line of two) and the
// closing pair up to three. The user must write coef_shift and
// lowpass_prescaled on the cfg port only while no pair is in flight; the
// block itself does not enforce this.
// ------------------------------------------------------------------------
module inverse_53_dwt_horizontal_line (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [idwt53_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [idwt53_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [idwt53_pkg::TDATA_W-1:0]      s_tdata,   // lowpass[31:0], highpass[47:32]
    input  logic                                s_tuser,   // has_highpass
    input  logic                                s_tlast,   // line_end
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [idwt53_pkg::SAMPLE_W-1:0]     m_tdata,   // sample
    output logic                                m_tlast    // sample_last
);
    import idwt53_pkg::*;

    logic     in_valid;
    in_item_t in_item;
    logic     in_take;
    logic     ev_valid;
    ev_item_t ev_item;
    logic     out_load_ok;

    idwt53_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .in_valid (in_valid),
        .in_item  (in_item),
        .in_take  (in_take)
    );

    idwt53_even_stage u_even (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_item     (in_item),
        .in_take     (in_take),
        .out_load_ok (out_load_ok),
        .ev_valid    (ev_valid),
        .ev_item     (ev_item)
    );

    idwt53_out_stage u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ev_valid    (ev_valid),
        .ev_item     (ev_item),
        .out_load_ok (out_load_ok),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule
